// File: rtl/sltbl_pkg.sv
// sltbl_pkg: constants, types and codes shared by the sorted leaf key table
// depends on nothing
package sltbl_pkg;

  localparam int Capacity = 64;
  localparam int Slots    = Capacity + 1;
  localparam int CntW     = $clog2(Slots + 1);

  typedef logic [1:0]  opcode_t;
  typedef logic [1:0]  status_t;
  typedef logic [31:0] key_t;
  typedef logic [30:0] id_t;
  typedef logic [6:0]  pos_t;
  typedef logic [CntW-1:0] cnt_t;

  localparam opcode_t OP_INSERT = 2'd0;
  localparam opcode_t OP_LOCATE = 2'd1;
  localparam opcode_t OP_READ   = 2'd2;
  localparam opcode_t OP_SPLIT  = 2'd3;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_MISSING = 2'd2;

  typedef struct packed {
    key_t key;
    id_t  page;
    id_t  slot;
  } entry_t;

  // per-cell control broadcast from the sequencer
  typedef struct packed {
    logic   shift_ins;  // insert: cells at or after pos take left neighbor or new entry
    logic   shift_out;  // split drain: cells at or after pos take their right neighbor
    cnt_t   pos;
    entry_t new_entry;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SKIP,
    S_DRAIN
  } state_t;

endpackage

// File: rtl/sorted_leaf_key_table_core.sv
// sorted_leaf_key_table_core: top level, a row of entry cells plus the sequencer
// depends on sltbl_pkg and sltbl_cell
//
//  channel | ports                                  | handshake
//  input   | in_opcode in_key in_page_id in_slot_id | start && !busy
//          | in_index                               |
//  result  | out_status out_position out_key ...    | out_valid, no stall
//
// insert, locate and read latch the request while idle, then in exec compare
// in every cell at once, shift the row and register the result. split-insert
// inserts and drops the count to keep in exec, then emits the tail one entry
// at a time: the row shifts left by one cell as entries go out, so cell keep
// always holds the next entry to emit. reset clears count, out_valid and the
// sequencer only; cell contents are read only below count, or at keep while a
// split emits. the receiver cannot stall, busy alone holds off new items.
module sorted_leaf_key_table_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  sltbl_pkg::opcode_t    in_opcode,
  input  logic signed [31:0]    in_key,
  input  logic [30:0]           in_page_id,
  input  logic [30:0]           in_slot_id,
  input  logic [6:0]            in_index,
  output logic                  out_valid,
  output sltbl_pkg::status_t    out_status,
  output logic [6:0]            out_position,
  output logic signed [31:0]    out_key,
  output logic [30:0]           out_page,
  output logic [30:0]           out_slot,
  output logic [6:0]            out_entry_count,
  output logic                  out_last
);

  localparam int N = sltbl_pkg::Slots;

  sltbl_pkg::state_t state_r, state_nxt;
  sltbl_pkg::cnt_t   count_r, count_nxt;
  sltbl_pkg::opcode_t op_r;
  sltbl_pkg::entry_t  in_r;
  logic [6:0]         idx_r;
  sltbl_pkg::cnt_t    pos_r, pos_nxt;     // insertion / split position
  sltbl_pkg::cnt_t    left_r, left_nxt;   // entries still to emit in a split
  sltbl_pkg::cnt_t    keep_r, keep_nxt;

  // result register
  logic               ov_r, ov_nxt;
  sltbl_pkg::status_t ost_r, ost_nxt;
  logic [6:0]         opos_r, opos_nxt;
  sltbl_pkg::entry_t  oent_r, oent_nxt;
  logic [6:0]         ocnt_r, ocnt_nxt;
  logic               olast_r, olast_nxt;

  sltbl_pkg::entry_t  ents [N];
  logic [N-1:0]       less_v;
  sltbl_pkg::cell_ctl_t ctl;
  sltbl_pkg::entry_t  zero_ent;

  assign zero_ent = '0;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      sltbl_pkg::entry_t lft, rgt;
      if (g == 0) begin : g_l0
        assign lft = zero_ent;
      end else begin : g_ln
        assign lft = ents[g-1];
      end
      if (g == N-1) begin : g_rn
        assign rgt = zero_ent;
      end else begin : g_r
        assign rgt = ents[g+1];
      end
      sltbl_cell u_cell (
        .clk         (clk),
        .my_idx      (sltbl_pkg::cnt_t'(g)),
        .ctl         (ctl),
        .left_entry  (lft),
        .right_entry (rgt),
        .search_key  (in_r.key),
        .entry       (ents[g]),
        .less        (less_v[g])
      );
    end
  endgenerate

  // insertion position: keys are sorted, so count of valid smaller keys
  logic [N-1:0]    lt_valid;
  sltbl_pkg::cnt_t find_pos;
  always_comb begin
    for (int i = 0; i < N; i++) begin
      lt_valid[i] = less_v[i] && (sltbl_pkg::cnt_t'(i) < count_r);
    end
    find_pos = sltbl_pkg::cnt_t'($countones(lt_valid));
  end

  // entry at find_pos / idx / keep through a mux
  sltbl_pkg::cnt_t   sel;
  sltbl_pkg::entry_t sel_ent;
  always_comb begin
    sel_ent = '0;
    for (int i = 0; i < N; i++) begin
      if (sltbl_pkg::cnt_t'(i) == sel) sel_ent = ents[i];
    end
  end

  assign busy            = (state_r != sltbl_pkg::S_IDLE);
  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_position    = opos_r;
  assign out_key         = oent_r.key;
  assign out_page        = oent_r.page;
  assign out_slot        = oent_r.slot;
  assign out_entry_count = ocnt_r;
  assign out_last        = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sltbl_pkg::S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r  <= in_opcode;
      in_r  <= '{key: in_key, page: in_page_id, slot: in_slot_id};
      idx_r <= in_index;
    end
    pos_r   <= pos_nxt;
    left_r  <= left_nxt;
    keep_r  <= keep_nxt;
    ost_r   <= ost_nxt;
    opos_r  <= opos_nxt;
    oent_r  <= oent_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
  end

  sltbl_pkg::cnt_t n_after;
  assign n_after = count_r + sltbl_pkg::cnt_t'(1);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    left_nxt  = left_r;
    keep_nxt  = keep_r;
    ov_nxt    = 1'b0;
    ost_nxt   = ost_r;
    opos_nxt  = opos_r;
    oent_nxt  = oent_r;
    ocnt_nxt  = ocnt_r;
    olast_nxt = olast_r;
    sel       = find_pos;
    ctl.shift_ins = 1'b0;
    ctl.shift_out = 1'b0;
    ctl.pos       = find_pos;
    ctl.new_entry = in_r;
    case (state_r)
      sltbl_pkg::S_IDLE: begin
        if (start) state_nxt = sltbl_pkg::S_EXEC;
      end
      sltbl_pkg::S_EXEC: begin
        state_nxt = sltbl_pkg::S_IDLE;
        ov_nxt    = 1'b1;
        olast_nxt = 1'b1;
        case (op_r)
          sltbl_pkg::OP_INSERT: begin
            if (count_r >= sltbl_pkg::cnt_t'(sltbl_pkg::Capacity)) begin
              ost_nxt  = sltbl_pkg::ST_FULL;
              opos_nxt = '0;
              oent_nxt = '0;
            end else begin
              ctl.shift_ins = 1'b1;
              count_nxt = n_after;
              ost_nxt   = sltbl_pkg::ST_OK;
              opos_nxt  = 7'(find_pos);
              oent_nxt  = in_r;
            end
            ocnt_nxt = 7'(count_nxt);
          end
          sltbl_pkg::OP_LOCATE: begin
            opos_nxt = 7'(find_pos);
            ocnt_nxt = 7'(count_r);
            if (find_pos < count_r && sel_ent.key == in_r.key) begin
              ost_nxt  = sltbl_pkg::ST_OK;
              oent_nxt = sel_ent;
            end else begin
              ost_nxt  = sltbl_pkg::ST_MISSING;
              oent_nxt = '0;
            end
          end
          sltbl_pkg::OP_READ: begin
            sel      = sltbl_pkg::cnt_t'(idx_r);
            opos_nxt = idx_r;
            ocnt_nxt = 7'(count_r);
            if ({1'b0, idx_r} < {1'b0, 7'(count_r)} &&
                sltbl_pkg::cnt_t'(idx_r) < count_r) begin
              ost_nxt  = sltbl_pkg::ST_OK;
              oent_nxt = sel_ent;
            end else begin
              ost_nxt  = sltbl_pkg::ST_MISSING;
              oent_nxt = '0;
            end
          end
          default: begin
            // split: insert always fits (count never reaches slots)
            ctl.shift_ins = 1'b1;
            pos_nxt   = find_pos;
            opos_nxt  = 7'(find_pos);
            keep_nxt  = (n_after >> 1) + sltbl_pkg::cnt_t'(1);
            if (keep_nxt >= n_after) begin
              count_nxt = n_after;
              ost_nxt   = sltbl_pkg::ST_MISSING;
              oent_nxt  = '0;
              ocnt_nxt  = 7'(n_after);
            end else begin
              // hold the result back while the row takes the insert, then drain
              count_nxt = keep_nxt;
              left_nxt  = n_after - keep_nxt;
              ov_nxt    = 1'b0;
              state_nxt = sltbl_pkg::S_SKIP;
            end
          end
        endcase
      end
      sltbl_pkg::S_SKIP, sltbl_pkg::S_DRAIN: begin
        // cell keep holds the next entry to emit; pull the row left after
        sel           = keep_r;
        ctl.shift_out = (state_r == sltbl_pkg::S_DRAIN);
        ctl.pos       = keep_r;
        if (state_r == sltbl_pkg::S_SKIP) begin
          ctl.shift_out = 1'b0;
        end
        ov_nxt    = 1'b1;
        ost_nxt   = sltbl_pkg::ST_OK;
        opos_nxt  = 7'(pos_r);
        oent_nxt  = sel_ent;
        ocnt_nxt  = 7'(count_r);
        olast_nxt = (left_r == sltbl_pkg::cnt_t'(1));
        left_nxt  = left_r - sltbl_pkg::cnt_t'(1);
        state_nxt = (left_r == sltbl_pkg::cnt_t'(1)) ? sltbl_pkg::S_IDLE
                                                     : sltbl_pkg::S_DRAIN;
        // shift only the tail so the kept head is untouched
        if (state_r == sltbl_pkg::S_SKIP || left_r != sltbl_pkg::cnt_t'(1)) begin
          ctl.shift_out = 1'b1;
        end
      end
      default: state_nxt = sltbl_pkg::S_IDLE;
    endcase
  end

endmodule

// File: rtl/sltbl_cell.sv
// sltbl_cell: one entry of the table, with its compare against the search key
// depends on sltbl_pkg
module sltbl_cell (
  input  logic                  clk,
  input  sltbl_pkg::cnt_t       my_idx,
  input  sltbl_pkg::cell_ctl_t  ctl,
  input  sltbl_pkg::entry_t     left_entry,
  input  sltbl_pkg::entry_t     right_entry,
  input  sltbl_pkg::key_t       search_key,
  output sltbl_pkg::entry_t     entry,
  output logic                  less
);

  sltbl_pkg::entry_t entry_r;

  assign entry = entry_r;
  assign less  = $signed(entry_r.key) < $signed(search_key);

  always_ff @(posedge clk) begin
    if (ctl.shift_ins) begin
      if (my_idx == ctl.pos) begin
        entry_r <= ctl.new_entry;
      end else if (my_idx > ctl.pos) begin
        entry_r <= left_entry;
      end
    end else if (ctl.shift_out && my_idx >= ctl.pos) begin
      entry_r <= right_entry;
    end
  end

endmodule

// File: rtl/sltbl_checker.sv
// sltbl_checker: port-level checks for the sorted leaf key table
// depends on sltbl_pkg and sorted_leaf_key_table_core (bind target)
module sltbl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input sltbl_pkg::status_t out_status,
  input logic [6:0]         out_entry_count,
  input logic               out_last
);

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid) else $error("not idle after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted item did not raise busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == sltbl_pkg::ST_OK || out_status == sltbl_pkg::ST_FULL ||
                  out_status == sltbl_pkg::ST_MISSING) else $error("bad status");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= 7'(sltbl_pkg::Capacity + 1))
    else $error("entry count too large");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy) else $error("busy after final result");

endmodule

bind sorted_leaf_key_table_core sltbl_checker u_sltbl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_entry_count (out_entry_count),
  .out_last        (out_last)
);
